FILE: hw/rtl/pic_pkg.sv
// shared types and constants for the priority interrupt controller
`default_nettype none

package pic_pkg;

  localparam int LINE_COUNT = 8;
  localparam int LINE_W     = 3;
  localparam int STEP_W     = 3;

  // operation codes carried on cmd
  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_RAISE  = 3'd2,
    CMD_ACK    = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  // init sequence steps
  localparam logic [STEP_W-1:0] STEP_SINGLE = 3'd1;
  localparam logic [STEP_W-1:0] STEP_VECTOR = 3'd2;
  localparam logic [STEP_W-1:0] STEP_CASC   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ICW4   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DONE   = 3'd5;

  // command byte decode
  localparam logic [7:0] INIT_FLAG  = 8'h10;
  localparam logic [7:0] OCW3_MASK  = 8'h98;
  localparam logic [7:0] OCW3_MATCH = 8'h08;
  localparam logic [7:0] EOI_FLAG   = 8'h20;

  // operation strobes shared by every line cell
  typedef struct packed {
    logic ack;
    logic eoi;
    logic mask_clear;
    logic mask_load;
  } pic_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/priority_interrupt_controller_top.sv
// Eight-line priority interrupt controller, top level with command decode.
// Usage: each transfer on the input channel (in_valid/in_stall with cmd,
// port_bit, write_data, irq_line) is one operation: register write, register
// read, line raise, acknowledge or missed timer tick. Every operation yields
// exactly one transfer on the output channel (out_valid/out_stall with
// result_data): read data, the vector on an acknowledge that grants a line, zero otherwise.
// The result is registered into the output register as the input transfer
// is taken. Throughput: one operation per cycle while the output is not
// stalled; the eight line cells resolve priority along their chain within
// the cycle, so only a stalled output holds back back-to-back operations.
// Stall: a waiting result holds in the output register; in_stall rises only
// while that register is full and out_stall is high, and a new operation is
// taken in the same cycle that the held result leaves.
// Reset: rst is synchronous and active high; all request, in-service and mask
// bits, the init step, single mode, vector base, read select and owed tick
// clear, and the output register empties.
`default_nettype none

module priority_interrupt_controller_top
  import pic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] cmd,
  input  wire logic       port_bit,
  input  wire logic [7:0] write_data,
  input  wire logic [2:0] irq_line,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      result_data
);

  logic                    accept;
  logic                    is_write;
  logic                    cmd_port_write;
  logic                    init_start;
  logic                    ocw3;
  logic                    eoi;
  logic                    data_write;
  logic [STEP_W-1:0]       step_eff;
  logic                    reraise;
  pic_ctl_t                ctl;
  logic [LINE_COUNT-1:0]   raise_vec;
  logic [LINE_COUNT-1:0]   reraise_vec;
  logic [LINE_COUNT:0]     ready_chain;
  logic [LINE_COUNT:0]     service_chain;
  logic [LINE_COUNT-1:0]   grant;
  logic [LINE_COUNT-1:0]   request_bits;
  logic [LINE_COUNT-1:0]   service_bits;
  logic [LINE_COUNT-1:0]   mask_bits;
  logic [LINE_W-1:0]       grant_line;
  logic [7:0]              result_next;

  logic                    read_service_select;
  logic [STEP_W-1:0]       init_step;
  logic                    single_mode;
  logic [7:0]              vector_base;
  logic                    tick_owed;

  // handshake
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // operation decode
  always_comb begin
    is_write       = accept && (cmd == CMD_WRITE);
    cmd_port_write = is_write && !port_bit;
    init_start     = cmd_port_write && ((write_data & INIT_FLAG) != 8'd0);
    ocw3           = cmd_port_write && !init_start &&
                     ((write_data & OCW3_MASK) == OCW3_MATCH);
    eoi            = cmd_port_write && !init_start &&
                     ((write_data & EOI_FLAG) != 8'd0);
    data_write     = is_write && port_bit;
    step_eff       = ((init_step == STEP_CASC) && single_mode) ? STEP_ICW4 : init_step;
    reraise        = eoi && service_bits[0] && tick_owed;
    ctl.ack        = accept && (cmd == CMD_ACK);
    ctl.eoi        = eoi;
    ctl.mask_clear = init_start;
    ctl.mask_load  = data_write && (step_eff >= STEP_DONE);
    raise_vec      = (accept && (cmd == CMD_RAISE)) ?
                     (LINE_COUNT'(1) << irq_line) : '0;
    reraise_vec    = {{(LINE_COUNT-1){1'b0}}, reraise};
  end

  // row of line cells, line 0 at the head of the chain
  assign ready_chain[0]   = 1'b0;
  assign service_chain[0] = 1'b0;

  for (genvar i = 0; i < LINE_COUNT; i++) begin : g_line
    pic_line_cell u_cell (
      .clk              (clk),
      .rst              (rst),
      .ctl              (ctl),
      .raise_hit        (raise_vec[i]),
      .reraise          (reraise_vec[i]),
      .mask_wdata       (write_data[i]),
      .ready_seen_in    (ready_chain[i]),
      .service_seen_in  (service_chain[i]),
      .ready_seen_out   (ready_chain[i+1]),
      .service_seen_out (service_chain[i+1]),
      .grant            (grant[i]),
      .request_bit      (request_bits[i]),
      .service_bit      (service_bits[i]),
      .mask_bit         (mask_bits[i])
    );
  end

  // encode the granted line
  always_comb begin
    grant_line = '0;
    for (int k = 0; k < LINE_COUNT; k++) begin
      if (grant[k]) begin
        grant_line = grant_line | LINE_W'(k);
      end
    end
  end

  // result select
  always_comb begin
    result_next = 8'd0;
    if (cmd == CMD_READ) begin
      if (port_bit) begin
        result_next = mask_bits;
      end else begin
        result_next = read_service_select ? service_bits : request_bits;
      end
    end else if ((cmd == CMD_ACK) && (grant != '0)) begin
      result_next = vector_base + 8'(grant_line);
    end
  end

  // init sequence and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_service_select <= 1'b0;
      init_step           <= '0;
      single_mode         <= 1'b0;
      vector_base         <= 8'd0;
      tick_owed           <= 1'b0;
    end else begin
      if (init_start) begin
        single_mode <= write_data[1];
        init_step   <= STEP_VECTOR;
      end
      if (ocw3 && write_data[1]) begin
        read_service_select <= write_data[0];
      end
      if (data_write && (step_eff < STEP_DONE)) begin
        if (step_eff == STEP_SINGLE) begin
          single_mode <= write_data[1];
        end
        if (step_eff == STEP_VECTOR) begin
          vector_base <= write_data;
        end
        init_step <= step_eff + STEP_W'(1);
      end
      if (reraise) begin
        tick_owed <= 1'b0;
      end else if (accept && (cmd == CMD_TICK)) begin
        tick_owed <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_data <= result_next;
    end
  end

  // checks
  a_grant_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(grant))
    else $error("more than one line granted");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted operation left no result");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    init_step <= STEP_DONE)
    else $error("init step out of range");

  a_reraise_sets: assert property (@(posedge clk) disable iff (rst)
    reraise |=> (request_bits[0] && !tick_owed && !service_bits[0]))
    else $error("owed tick not re-raised on line 0");

  a_grant_moves: assert property (@(posedge clk) disable iff (rst)
    (grant != '0) |=> ((service_bits & $past(grant)) == $past(grant)))
    else $error("granted line not marked in service");

endmodule

`default_nettype wire

FILE: hw/rtl/pic_line_cell.sv
// one interrupt line: request, in-service and mask bits plus priority chain links
`default_nettype none

module pic_line_cell
  import pic_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire pic_ctl_t ctl,
  input  wire logic     raise_hit,
  input  wire logic     reraise,
  input  wire logic     mask_wdata,
  input  wire logic     ready_seen_in,
  input  wire logic     service_seen_in,
  output logic          ready_seen_out,
  output logic          service_seen_out,
  output logic          grant,
  output logic          request_bit,
  output logic          service_bit,
  output logic          mask_bit
);

  logic ready;
  logic eoi_clear;
  logic request_bit_next;
  logic service_bit_next;
  logic mask_bit_next;

  // priority chain: lower lines win
  always_comb begin
    ready            = request_bit & ~mask_bit;
    grant            = ctl.ack & ready & ~ready_seen_in;
    ready_seen_out   = ready_seen_in | ready;
    eoi_clear        = ctl.eoi & service_bit & ~service_seen_in;
    service_seen_out = service_seen_in | service_bit;
  end

  // next bit values
  always_comb begin
    request_bit_next = (request_bit & ~grant) | raise_hit | reraise;
    service_bit_next = (service_bit | grant) & ~eoi_clear;
    if (ctl.mask_clear) begin
      mask_bit_next = 1'b0;
    end else if (ctl.mask_load) begin
      mask_bit_next = mask_wdata;
    end else begin
      mask_bit_next = mask_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_bit <= 1'b0;
      service_bit <= 1'b0;
      mask_bit    <= 1'b0;
    end else begin
      request_bit <= request_bit_next;
      service_bit <= service_bit_next;
      mask_bit    <= mask_bit_next;
    end
  end

endmodule

`default_nettype wire
